/* rtl/core/ferp_pkg.sv */
`default_nettype none
package ferp_pkg;

	localparam int unsigned ReqAddrWidth = 32;
	localparam int unsigned ReqLenWidth  = 25;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_ABORT  = 2'd2;

	localparam logic [1:0] SIZE_4K  = 2'd0;
	localparam logic [1:0] SIZE_32K = 2'd1;
	localparam logic [1:0] SIZE_64K = 2'd2;

	localparam logic [31:0] BLK64 = 32'h0001_0000;
	localparam logic [31:0] BLK32 = 32'h0000_8000;
	localparam logic [31:0] BLK4  = 32'h0000_1000;

	typedef struct packed {
		logic [1:0]              op;
		logic [ReqAddrWidth-1:0] range_start;
		logic [ReqLenWidth-1:0]  range_length;
	} req_t;

	typedef struct packed {
		logic                    erase_issue;
		logic [1:0]              erase_size;
		logic [ReqAddrWidth-1:0] erase_address;
		logic                    status;
	} rsp_t;

endpackage
`default_nettype wire

/* rtl/core/ferp_step.sv */
`default_nettype none
module ferp_step #(
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  wire ferp_pkg::req_t  req,
	input  wire                  open_cur,
	input  wire [ADDR_WIDTH-1:0] end_cur,
	input  wire [ADDR_WIDTH-1:0] done_cur,
	output ferp_pkg::rsp_t       rsp,
	output logic                 open_nxt,
	output logic [ADDR_WIDTH-1:0] end_nxt,
	output logic [ADDR_WIDTH-1:0] done_nxt
);

	logic [ADDR_WIDTH-1:0] start_a;
	logic [ADDR_WIDTH-1:0] len_a;
	logic [ADDR_WIDTH-1:0] blk64_a;
	logic [ADDR_WIDTH-1:0] fin_rem;
	logic [31:0]           fin_rem32;
	logic [ADDR_WIDTH-1:0] cont_end;
	logic [ADDR_WIDTH-1:0] cont_rem;
	logic                  len_big;

	// Result of a single finish step on the open range.
	logic                  fin_issue;
	logic [1:0]            fin_size;
	logic [ADDR_WIDTH-1:0] fin_blk;
	logic                  fin_open;
	logic [ADDR_WIDTH-1:0] fin_done;

	assign start_a   = ADDR_WIDTH'(req.range_start);
	assign len_a     = ADDR_WIDTH'(req.range_length);
	assign blk64_a   = ADDR_WIDTH'(ferp_pkg::BLK64);
	assign fin_rem   = end_cur - done_cur;
	assign fin_rem32 = 32'(fin_rem);
	assign cont_end  = end_cur + len_a;
	assign cont_rem  = cont_end - done_cur;
	assign len_big   = 32'(req.range_length) > ferp_pkg::BLK64;

	always_comb begin
		if (fin_rem32 > ferp_pkg::BLK64) begin
			fin_size = ferp_pkg::SIZE_64K;
			fin_blk  = blk64_a;
		end else if (fin_rem32 > ferp_pkg::BLK32) begin
			fin_size = ferp_pkg::SIZE_32K;
			fin_blk  = ADDR_WIDTH'(ferp_pkg::BLK32);
		end else begin
			fin_size = ferp_pkg::SIZE_4K;
			fin_blk  = ADDR_WIDTH'(ferp_pkg::BLK4);
		end
		fin_issue = open_cur && (fin_rem != '0);
		fin_done  = fin_issue ? done_cur + fin_blk : done_cur;
		// A block that covers the whole remainder closes the range, even past the end.
		fin_open  = fin_issue && (fin_rem > fin_blk);
	end

	always_comb begin
		rsp      = '0;
		open_nxt = open_cur;
		end_nxt  = end_cur;
		done_nxt = done_cur;
		case (req.op)
			ferp_pkg::OP_ADD: begin
				if (!open_cur) begin
					if (len_big) begin
						rsp.erase_issue   = 1'b1;
						rsp.erase_size    = ferp_pkg::SIZE_64K;
						rsp.erase_address = 32'(start_a);
						done_nxt          = start_a + blk64_a;
					end else begin
						done_nxt = start_a;
					end
					end_nxt  = start_a + len_a;
					open_nxt = req.range_length != '0;
				end else if (start_a == end_cur) begin
					if (32'(cont_rem) > ferp_pkg::BLK64) begin
						rsp.erase_issue   = 1'b1;
						rsp.erase_size    = ferp_pkg::SIZE_64K;
						rsp.erase_address = 32'(done_cur);
						done_nxt          = done_cur + blk64_a;
					end
					end_nxt = cont_end;
				end else begin
					// Drain the old range first; the caller repeats this request.
					if (fin_issue) begin
						rsp.erase_issue   = 1'b1;
						rsp.erase_size    = fin_size;
						rsp.erase_address = 32'(done_cur);
					end
					done_nxt   = fin_done;
					open_nxt   = fin_open;
					rsp.status = 1'b1;
				end
			end
			ferp_pkg::OP_FINISH: begin
				if (fin_issue) begin
					rsp.erase_issue   = 1'b1;
					rsp.erase_size    = fin_size;
					rsp.erase_address = 32'(done_cur);
				end
				done_nxt   = fin_done;
				open_nxt   = fin_open;
				rsp.status = fin_open;
			end
			ferp_pkg::OP_ABORT: begin
				open_nxt = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/flash_erase_range_planner_top.sv */
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   ferp_pkg::req_t (op, range_start, range_length)
// rsp      out        rsp_valid/rsp_stall   ferp_pkg::rsp_t (erase_issue, erase_size,
//                                           erase_address, status)
//
// One transaction per cycle while req_stall is low; each produces exactly one response.
// The request is registered, then the planning step and range state update run
// combinationally into the response register. State is only touched when the response
// register can load. Reset clears the open flag, both addresses and the valid flags.
// A stalled response holds its register, and req_stall rises only when both registers are full.
module flash_erase_range_planner_top #(
	parameter int unsigned ADDR_WIDTH = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  wire ferp_pkg::req_t req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output ferp_pkg::rsp_t rsp
);

	ferp_pkg::req_t        req_s1;
	logic                  valid_s1;
	logic                  adv;
	logic                  open_q;
	logic [ADDR_WIDTH-1:0] end_q;
	logic [ADDR_WIDTH-1:0] done_q;
	ferp_pkg::rsp_t        rsp_d;
	logic                  open_d;
	logic [ADDR_WIDTH-1:0] end_d;
	logic [ADDR_WIDTH-1:0] done_d;
	ferp_pkg::rsp_t        rsp_q;
	logic                  rsp_valid_q;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ferp_step #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_step (
		.req      (req_s1),
		.open_cur (open_q),
		.end_cur  (end_q),
		.done_cur (done_q),
		.rsp      (rsp_d),
		.open_nxt (open_d),
		.end_nxt  (end_d),
		.done_nxt (done_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			open_q      <= 1'b0;
			end_q       <= '0;
			done_q      <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
				open_q      <= open_d;
				end_q       <= end_d;
				done_q      <= done_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire
